@@ sv/smtq_pkg.sv @@
// ----------------------------------------------------------------------------
// smtq_pkg
// Shared types and constants of the sorted multi-timer queue.
// ----------------------------------------------------------------------------
package smtq_pkg;

    localparam int unsigned TIMERS_DEF = 32;
    localparam int unsigned ID_W       = 5;
    localparam int unsigned LINK_W     = 6;
    localparam logic [31:0] FAR_DEADLINE = 32'hffff_ffff;

    typedef enum logic [2:0] {
        ACT_ALLOC  = 3'd0,
        ACT_FREE   = 3'd1,
        ACT_SET    = 3'd2,
        ACT_ARM    = 3'd3,
        ACT_CANCEL = 3'd4,
        ACT_TICK   = 3'd5
    } t_action;

    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_ALLOC   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;

endpackage

@@ sv/sorted_multi_timer_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_multi_timer_queue
// Timer pool with a deadline-sorted list of running timers.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis; tdata carries action, timer_id, delay_ticks,
//   event_word and owner_id from bit 0 up. Results leave on m_axis: tdata
//   carries slot, expiry_word and expiry_owner from bit 0 up, tuser carries
//   kind, ok and switch_task from bit 0 up, tlast marks the closing status.
//   i_task_wr writes the task timer slot (TIMERS or more means none).
// Sequencing:
//   One request at a time; each list step reads the single table port and
//   then compares. Set, cancel miss, free of a stopped slot and unknown
//   actions go straight to the status; allocate scans one status bit per
//   cycle; a tick walks the expired entries from the head; an arm unlinks
//   a running slot, then reinserts it in deadline order.
//   Each result waits in the output register until taken, stalling the walk
//   and the input.
// Reset: synchronous, active low. Counter cleared, list empty, all slots
//   free, no task timer. Slot data tables are not cleared.
// ----------------------------------------------------------------------------
module sorted_multi_timer_queue #(
    parameter int unsigned TIMERS = smtq_pkg::TIMERS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_task_wr,
    input  logic [5:0]   i_task_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[2:0], timer_id[7:3], delay_ticks[39:8], event_word[71:40],
    // owner_id[79:72]
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // slot[4:0], expiry_word[36:5], expiry_owner[44:37], zero fill
    output logic [47:0]  m_axis_tdata,
    // kind[0], ok[1], switch_task[2]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int unsigned LW = smtq_pkg::LINK_W;
    localparam logic [LW-1:0] NOSLOT = LW'(TIMERS);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_ALLOC, S_UNLINK_RD, S_UNLINK_CHK,
        S_INS_RD, S_INS_CHK, S_INS_DONE, S_TICK_RD, S_TICK_CHK,
        S_EMIT, S_STATUS
    } t_state;

    t_state r_state;

    // slot tables
    logic [31:0]            r_mem_dl   [TIMERS];
    logic [LW-1:0]          r_mem_link [TIMERS];
    logic [7:0]             r_mem_own  [TIMERS];
    logic [31:0]            r_mem_word [TIMERS];
    logic [1:0]             r_status   [TIMERS];

    logic [5:0]             r_task;
    logic [31:0]            r_count;
    logic [31:0]            r_next_dl;
    logic [LW-1:0]          r_head;

    // request registers
    logic [2:0]             r_act;
    logic [4:0]             r_id;
    logic [31:0]            r_delay;
    logic                   r_arm_after;

    // set payload held from the request
    logic [7:0]             r_odata_own_in;
    logic [31:0]            r_word_in;

    // walk registers
    logic [LW-1:0]          r_cur;
    logic [LW-1:0]          r_prev;
    logic [4:0]             r_scan;
    logic [31:0]            r_rd_dl;
    logic [LW-1:0]          r_rd_link;
    logic [7:0]             r_rd_own;
    logic [31:0]            r_rd_word;
    logic [31:0]            r_new_dl;
    logic [LW-1:0]          r_id_link;

    // status fields
    logic [4:0]             r_st_slot;
    logic                   r_ok;
    logic                   r_sw;

    // output register
    logic                   r_ovalid;
    logic [47:0]            r_odata;
    logic [2:0]             r_ouser;
    logic                   r_olast;

    // shared table access
    logic                   mem_rd;
    logic [4:0]             mem_raddr;
    logic                   link_we;
    logic [4:0]             link_waddr;
    logic [LW-1:0]          link_wdata;
    logic                   dl_we;

    logic                   id_ok;
    assign id_ok = (32'(r_id) < TIMERS);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    // read address selection for the shared port
    always_comb begin
        mem_rd    = 1'b0;
        mem_raddr = r_cur[4:0];
        case (r_state) inside
            S_UNLINK_RD, S_INS_RD, S_TICK_RD: mem_rd = 1'b1;
            default: mem_rd = 1'b0;
        endcase
    end

    // slot table port: one read, link/deadline writes, set payload writes
    always_ff @(posedge i_clk) begin
        if (mem_rd) begin
            r_rd_dl   <= r_mem_dl[mem_raddr];
            r_rd_link <= r_mem_link[mem_raddr];
            r_rd_own  <= r_mem_own[mem_raddr];
            r_rd_word <= r_mem_word[mem_raddr];
        end
        if (link_we) begin
            r_mem_link[link_waddr] <= link_wdata;
        end
        if (dl_we) begin
            r_mem_dl[r_id] <= r_new_dl;
        end
        if (r_state == S_DISPATCH && r_act == smtq_pkg::ACT_SET && id_ok) begin
            r_mem_own[r_id]  <= r_odata_own_in;
            r_mem_word[r_id] <= r_word_in;
        end
    end

    // link write decode
    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_prev[4:0];
        link_wdata = r_id_link;
        dl_we      = 1'b0;
        case (r_state)
            S_UNLINK_CHK: begin
                // predecessor found: bypass the removed slot
                if (r_rd_link == {1'b0, r_id}) begin
                    link_we    = 1'b1;
                    link_waddr = r_cur[4:0];
                    link_wdata = r_id_link;
                end
            end
            S_INS_DONE: begin
                link_we    = 1'b1;
                link_waddr = r_id;
                link_wdata = r_cur;
                dl_we      = 1'b1;
            end
            S_INS_CHK: begin
                if (r_cur == NOSLOT || r_new_dl <= r_rd_dl) begin
                    if (r_prev != NOSLOT) begin
                        link_we    = 1'b1;
                        link_waddr = r_prev[4:0];
                        link_wdata = {1'b0, r_id};
                    end
                end
            end
            default: link_we = 1'b0;
        endcase
    end

    // link of the addressed slot, read once per request
    logic [LW-1:0] id_link_rd;
    assign id_link_rd = r_mem_link[r_id];

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_task    <= 6'd32;
            r_count   <= '0;
            r_next_dl <= smtq_pkg::FAR_DEADLINE;
            r_head    <= NOSLOT;
            r_ovalid  <= 1'b0;
            for (int i = 0; i < TIMERS; i++) begin
                r_status[i] <= smtq_pkg::ST_FREE;
            end
        end else begin
            if (i_task_wr) begin
                r_task <= i_task_data;
            end
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_act          <= s_axis_tdata[2:0];
                        r_id           <= s_axis_tdata[7:3];
                        r_delay        <= s_axis_tdata[39:8];
                        r_word_in      <= s_axis_tdata[71:40];
                        r_odata_own_in <= s_axis_tdata[79:72];
                        r_st_slot      <= '0;
                        r_ok           <= 1'b0;
                        r_sw           <= 1'b0;
                        r_scan         <= '0;
                        r_state        <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_id_link   <= id_link_rd;
                    r_new_dl    <= r_delay + r_count;
                    r_arm_after <= (r_act == smtq_pkg::ACT_ARM);
                    r_state     <= S_STATUS;
                    case (r_act) inside
                        smtq_pkg::ACT_ALLOC: r_state <= S_ALLOC;
                        smtq_pkg::ACT_FREE, smtq_pkg::ACT_ARM,
                        smtq_pkg::ACT_CANCEL: begin
                            if (id_ok && r_status[r_id] == smtq_pkg::ST_RUNNING) begin
                                if (r_act == smtq_pkg::ACT_CANCEL) begin
                                    r_ok <= 1'b1;
                                    r_status[r_id] <= smtq_pkg::ST_ALLOC;
                                end else if (r_act == smtq_pkg::ACT_FREE) begin
                                    r_status[r_id] <= smtq_pkg::ST_FREE;
                                end
                                // remove from the list first
                                if (r_head == {1'b0, r_id}) begin
                                    r_head <= id_link_rd;
                                    if (id_link_rd == NOSLOT) begin
                                        r_next_dl <= smtq_pkg::FAR_DEADLINE;
                                        r_state   <= (r_act == smtq_pkg::ACT_ARM)
                                                     ? S_INS_RD : S_STATUS;
                                        r_cur     <= id_link_rd;
                                        r_prev    <= NOSLOT;
                                    end else begin
                                        // need head deadline: read it
                                        r_cur   <= id_link_rd;
                                        r_prev  <= NOSLOT;
                                        r_state <= S_UNLINK_RD;
                                    end
                                end else begin
                                    r_cur   <= r_head;
                                    r_prev  <= NOSLOT;
                                    r_state <= S_UNLINK_RD;
                                end
                            end else if (id_ok) begin
                                if (r_act == smtq_pkg::ACT_FREE) begin
                                    r_status[r_id] <= smtq_pkg::ST_FREE;
                                end
                                if (r_act == smtq_pkg::ACT_ARM) begin
                                    r_cur   <= r_head;
                                    r_prev  <= NOSLOT;
                                    r_state <= S_INS_RD;
                                end
                            end
                            if (id_ok && r_act == smtq_pkg::ACT_ARM) begin
                                r_status[r_id] <= smtq_pkg::ST_RUNNING;
                            end
                        end
                        smtq_pkg::ACT_TICK: begin
                            r_count <= r_count + 32'd1;
                            if (r_next_dl <= r_count + 32'd1) begin
                                r_cur   <= r_head;
                                r_state <= S_TICK_RD;
                            end
                        end
                        default: r_state <= S_STATUS;
                    endcase
                end
                // lowest free slot, one per cycle
                S_ALLOC: begin
                    if (r_status[r_scan] == smtq_pkg::ST_FREE) begin
                        r_status[r_scan] <= smtq_pkg::ST_ALLOC;
                        r_st_slot <= r_scan;
                        r_ok      <= 1'b1;
                        r_state   <= S_STATUS;
                    end else if (32'(r_scan) == TIMERS - 1) begin
                        r_state <= S_STATUS;
                    end else begin
                        r_scan <= r_scan + 5'd1;
                    end
                end
                S_UNLINK_RD: begin
                    r_state <= S_UNLINK_CHK;
                end
                S_UNLINK_CHK: begin
                    if (r_head == r_id_link && r_prev == NOSLOT
                        && r_cur == r_id_link) begin
                        // head was removed: refresh cached deadline
                        r_next_dl <= r_rd_dl;
                        r_cur     <= r_head;
                        r_state   <= r_arm_after ? S_INS_RD : S_STATUS;
                    end else if (r_rd_link == {1'b0, r_id} || r_rd_link == NOSLOT
                                 || r_cur == NOSLOT) begin
                        r_cur   <= r_head;
                        r_state <= r_arm_after ? S_INS_RD : S_STATUS;
                    end else begin
                        r_cur   <= r_rd_link;
                        r_state <= S_UNLINK_RD;
                    end
                    r_prev <= NOSLOT;
                end
                S_INS_RD: begin
                    if (r_cur == NOSLOT) begin
                        r_state <= S_INS_CHK;
                    end else begin
                        r_state <= S_INS_CHK;
                    end
                end
                S_INS_CHK: begin
                    if (r_cur == NOSLOT || r_new_dl <= r_rd_dl) begin
                        if (r_prev == NOSLOT) begin
                            r_head    <= {1'b0, r_id};
                            r_next_dl <= r_new_dl;
                        end
                        r_state <= S_INS_DONE;
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= r_rd_link;
                        r_state <= S_INS_RD;
                    end
                end
                S_INS_DONE: begin
                    r_state <= S_STATUS;
                end
                S_TICK_RD: begin
                    r_state <= S_TICK_CHK;
                end
                S_TICK_CHK: begin
                    if (r_cur == NOSLOT || r_rd_dl > r_count) begin
                        r_head    <= r_cur;
                        r_next_dl <= (r_cur == NOSLOT) ? smtq_pkg::FAR_DEADLINE
                                                       : r_rd_dl;
                        r_state   <= S_STATUS;
                    end else begin
                        r_status[r_cur[4:0]] <= smtq_pkg::ST_ALLOC;
                        if ({1'b0, r_cur} == {1'b0, r_task}) begin
                            r_sw    <= 1'b1;
                            r_cur   <= r_rd_link;
                            r_state <= S_TICK_RD;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                // expiry event waits for the output register
                S_EMIT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {3'd0, r_rd_own, r_rd_word, r_cur[4:0]};
                        r_ouser  <= 3'b000;
                        r_olast  <= 1'b0;
                        r_cur    <= r_rd_link;
                        r_state  <= S_TICK_RD;
                    end
                end
                S_STATUS: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {43'd0, r_st_slot};
                        r_ouser  <= {r_sw, r_ok, 1'b1};
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // an accepted request never overlaps a pending walk
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while busy");

    // a finished status returns the block to idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STATUS && (!r_ovalid || m_axis_tready)) |=>
        (s_axis_tready && m_axis_tlast))
        else $error("status not followed by idle");

    // expiry events never carry ok or switch flags
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == 3'b000))
        else $error("bad expiry flags");

endmodule

@@ tb/sorted_multi_timer_queue_test.sv @@
// ----------------------------------------------------------------------------
// sorted_multi_timer_queue_test
// Self-checking testbench for the sorted multi-timer queue. A short table of
// directed requests is followed by random traffic in several phases, each
// with its own task timer setting and idling mix. Every accepted request
// is run through a local model of the timer pool and the results it predicts
// are compared field by field with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_multi_timer_queue_test;

    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;
    localparam logic [5:0] NO_SLOT    = 6'd32;
    localparam int         DRAIN_CYC  = 100;

    typedef struct packed {
        logic        kind;
        logic [4:0]  slot;
        logic [31:0] word;
        logic [7:0]  owner;
        logic        ok;
        logic        sw;
        logic        last;
    } t_result;

    typedef struct {
        logic [2:0]  act;
        logic [4:0]  id;
        logic [31:0] delay;
        logic [31:0] word;
        logic [7:0]  owner;
        bit          typed;
        logic        exp_ok;
        logic [4:0]  exp_slot;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_task_wr;
    logic [5:0]   i_task_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    // model of the timer pool
    logic [1:0]   pool_state [32];
    logic [31:0]  pool_deadline [32];
    logic [5:0]   pool_link [32];
    logic [7:0]   pool_owner [32];
    logic [31:0]  pool_word [32];
    bit           pool_written [32];
    logic [5:0]   list_head;
    logic [31:0]  head_deadline;
    logic [31:0]  tick_total;
    logic [5:0]   task_slot;

    t_result      pending_results [$];
    int           errors;
    int           requests_sent;
    int           events_seen;
    int           switches_seen;
    int           send_idle;
    int           recv_idle;
    int           recv_hold;

    sorted_multi_timer_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_task_wr     (i_task_wr),
        .i_task_data   (i_task_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    // take a running slot out of the list
    function automatic void list_remove(input logic [4:0] id);
        logic [5:0] p;
        p = list_head;
        if (list_head == {1'b0, id}) begin
            list_head     = pool_link[id];
            head_deadline = list_head[5] ? smtq_pkg::FAR_DEADLINE
                                         : pool_deadline[list_head[4:0]];
            return;
        end
        for (int n = 0; n < 32 && !p[5]; n++) begin
            if (pool_link[p[4:0]] == {1'b0, id}) begin
                pool_link[p[4:0]] = pool_link[id];
                return;
            end
            p = pool_link[p[4:0]];
        end
    endfunction

    // sorted insert, ahead of equal deadlines
    function automatic void list_insert(input logic [4:0] id, input logic [31:0] dl);
        logic [5:0] prev;
        logic [5:0] cur;
        prev = NO_SLOT;
        cur  = list_head;
        for (int n = 0; n < 32; n++) begin
            if (cur[5] || dl <= pool_deadline[cur[4:0]]) break;
            prev = cur;
            cur  = pool_link[cur[4:0]];
        end
        if (prev[5]) begin
            list_head     = {1'b0, id};
            head_deadline = dl;
        end else begin
            pool_link[prev[4:0]] = {1'b0, id};
        end
        pool_link[id] = cur;
    endfunction

    // apply one request to the model and queue up the results it causes
    function automatic t_result timer_step(input logic [2:0] act, input logic [4:0] id,
                                           input logic [31:0] delay,
                                           input logic [31:0] word,
                                           input logic [7:0] owner);
        t_result    st;
        t_result    ev;
        logic [5:0] h;
        st = '0;
        st.kind = 1'b1;
        st.last = 1'b1;
        case (act)
            smtq_pkg::ACT_ALLOC: begin
                for (int i = 0; i < 32; i++) begin
                    if (pool_state[i] == smtq_pkg::ST_FREE) begin
                        pool_state[i] = smtq_pkg::ST_ALLOC;
                        st.slot = i[4:0];
                        st.ok   = 1'b1;
                        break;
                    end
                end
            end
            smtq_pkg::ACT_FREE: begin
                if (pool_state[id] == smtq_pkg::ST_RUNNING) list_remove(id);
                pool_state[id] = smtq_pkg::ST_FREE;
            end
            smtq_pkg::ACT_SET: begin
                pool_owner[id]   = owner;
                pool_word[id]    = word;
                pool_written[id] = 1'b1;
            end
            smtq_pkg::ACT_ARM: begin
                if (pool_state[id] == smtq_pkg::ST_RUNNING) list_remove(id);
                pool_deadline[id] = delay + tick_total;
                pool_state[id]    = smtq_pkg::ST_RUNNING;
                list_insert(id, pool_deadline[id]);
            end
            smtq_pkg::ACT_CANCEL: begin
                if (pool_state[id] == smtq_pkg::ST_RUNNING) begin
                    list_remove(id);
                    pool_state[id] = smtq_pkg::ST_ALLOC;
                    st.ok = 1'b1;
                end
            end
            smtq_pkg::ACT_TICK: begin
                tick_total = tick_total + 32'd1;
                if (head_deadline <= tick_total) begin
                    h = list_head;
                    for (int n = 0; n < 32; n++) begin
                        if (h[5] || pool_deadline[h[4:0]] > tick_total) break;
                        pool_state[h[4:0]] = smtq_pkg::ST_ALLOC;
                        if (h == task_slot) begin
                            st.sw = 1'b1;
                        end else begin
                            ev       = '0;
                            ev.slot  = h[4:0];
                            ev.word  = pool_word[h[4:0]];
                            ev.owner = pool_owner[h[4:0]];
                            pending_results.push_back(ev);
                        end
                        h = pool_link[h[4:0]];
                    end
                    list_head     = h;
                    head_deadline = h[5] ? smtq_pkg::FAR_DEADLINE : pool_deadline[h[4:0]];
                end
            end
            default: ;
        endcase
        pending_results.push_back(st);
        return st;
    endfunction

    // offer one request and wait for it to be taken
    task automatic send_request(input logic [2:0] act, input logic [4:0] id,
                                input logic [31:0] delay, input logic [31:0] word,
                                input logic [7:0] owner, output t_result st);
        if ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {owner, word, delay, id, act};
        do @(posedge i_clk); while (!s_axis_tready);
        st = timer_step(act, id, delay, word, owner);
        requests_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_task_slot(input logic [5:0] v);
        i_task_wr   <= 1'b1;
        i_task_data <= v;
        @(posedge i_clk);
        i_task_wr   <= 1'b0;
        task_slot = v;
    endtask

    // random request, mostly well-formed so timers actually run and expire
    task automatic random_request(input int free_weight);
        logic [2:0]  act;
        logic [4:0]  id;
        logic [31:0] delay;
        int          r;
        t_result     st;
        r  = $urandom_range(99);
        id = 5'($urandom);
        if (r < 14)                    act = smtq_pkg::ACT_ALLOC;
        else if (r < 14 + free_weight) act = smtq_pkg::ACT_FREE;
        else if (r < 40)               act = smtq_pkg::ACT_SET;
        else if (r < 62)               act = smtq_pkg::ACT_ARM;
        else if (r < 70)               act = smtq_pkg::ACT_CANCEL;
        else if (r < 98)               act = smtq_pkg::ACT_TICK;
        else                           act = r[0] ? ACT_SPARE6 : ACT_SPARE7;
        // never arm a slot whose owner/data has not been set
        if (act == smtq_pkg::ACT_ARM && !pool_written[id]) act = smtq_pkg::ACT_SET;
        r = $urandom_range(99);
        if (r < 80)      delay = $urandom_range(0, 6);
        else if (r < 95) delay = $urandom;
        else             delay = smtq_pkg::FAR_DEADLINE;
        send_request(act, id, delay, $urandom, 8'($urandom), st);
    endtask

    // receiver ready, with random idling and long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold     <= recv_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind  = m_axis_tuser[0];
            got.ok    = m_axis_tuser[1];
            got.sw    = m_axis_tuser[2];
            got.slot  = m_axis_tdata[4:0];
            got.word  = m_axis_tdata[36:5];
            got.owner = m_axis_tdata[44:37];
            got.last  = m_axis_tlast;
            if (pending_results.size() == 0) begin
                $error("unexpected result %p", got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind) begin
                    $error("kind: expected %0d got %0d", want.kind, got.kind); errors++;
                end
                if (got.slot !== want.slot) begin
                    $error("slot: expected %0d got %0d", want.slot, got.slot); errors++;
                end
                if (got.word !== want.word) begin
                    $error("expiry_word: expected %h got %h", want.word, got.word); errors++;
                end
                if (got.owner !== want.owner) begin
                    $error("expiry_owner: expected %h got %h", want.owner, got.owner);
                    errors++;
                end
                if (got.ok !== want.ok) begin
                    $error("ok: expected %0d got %0d", want.ok, got.ok); errors++;
                end
                if (got.sw !== want.sw) begin
                    $error("switch_task: expected %0d got %0d", want.sw, got.sw); errors++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d got %0d", want.last, got.last); errors++;
                end
                if (!want.kind) events_seen++;
                if (want.sw) switches_seen++;
            end
        end
    end

    // stimulus
    initial begin
        t_row        rows [$];
        t_result     st;
        logic [5:0]  task_values [4];
        int          idle_mix [4][2];

        rows = '{
            '{smtq_pkg::ACT_ALLOC, 5'd0, 32'd0, 32'd0, 8'd0, 1, 1'b1, 5'd0},
            '{smtq_pkg::ACT_ALLOC, 5'd0, 32'd0, 32'd0, 8'd0, 1, 1'b1, 5'd1},
            '{smtq_pkg::ACT_SET, 5'd0, 32'd0, 32'hffff_ffff, 8'hff, 0, 1'b0, 5'd0},
            '{smtq_pkg::ACT_SET, 5'd1, 32'hffff_ffff, 32'd0, 8'd0, 0, 1'b0, 5'd0},
            '{smtq_pkg::ACT_ARM, 5'd0, 32'd0, 32'd0, 8'd0, 0, 1'b0, 5'd0},
            '{smtq_pkg::ACT_ARM, 5'd1, 32'hffff_ffff, 32'd0, 8'd0, 0, 1'b0, 5'd0},
            '{smtq_pkg::ACT_TICK, 5'd0, 32'd0, 32'd0, 8'd0, 0, 1'b0, 5'd0},
            '{smtq_pkg::ACT_CANCEL, 5'd1, 32'd0, 32'd0, 8'd0, 1, 1'b1, 5'd0},
            '{smtq_pkg::ACT_CANCEL, 5'd1, 32'd0, 32'd0, 8'd0, 1, 1'b0, 5'd0},
            '{smtq_pkg::ACT_ARM, 5'd1, 32'd2, 32'd0, 8'd0, 0, 1'b0, 5'd0},
            // equal deadline goes in ahead
            '{smtq_pkg::ACT_ARM, 5'd0, 32'd2, 32'd0, 8'd0, 0, 1'b0, 5'd0},
            // re-arm of a running timer
            '{smtq_pkg::ACT_ARM, 5'd0, 32'd1, 32'd0, 8'd0, 0, 1'b0, 5'd0},
            '{smtq_pkg::ACT_TICK, 5'd0, 32'd0, 32'd0, 8'd0, 0, 1'b0, 5'd0},
            '{smtq_pkg::ACT_TICK, 5'd0, 32'd0, 32'd0, 8'd0, 0, 1'b0, 5'd0},
            '{smtq_pkg::ACT_FREE, 5'd1, 32'd0, 32'd0, 8'd0, 0, 1'b0, 5'd0},
            '{smtq_pkg::ACT_SET, 5'd31, 32'd0, 32'h5a5a_a5a5, 8'h80, 0, 1'b0, 5'd0},
            // arm of a free slot, then free while running
            '{smtq_pkg::ACT_ARM, 5'd31, 32'd1, 32'd0, 8'd0, 0, 1'b0, 5'd0},
            '{smtq_pkg::ACT_FREE, 5'd31, 32'd0, 32'd0, 8'd0, 0, 1'b0, 5'd0},
            '{ACT_SPARE6, 5'd31, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 1, 1'b0, 5'd0},
            '{ACT_SPARE7, 5'd0, 32'd0, 32'd0, 8'd0, 1, 1'b0, 5'd0},
            '{smtq_pkg::ACT_ALLOC, 5'd0, 32'd0, 32'd0, 8'd0, 1, 1'b1, 5'd1},
            '{smtq_pkg::ACT_TICK, 5'd0, 32'd0, 32'd0, 8'd0, 0, 1'b0, 5'd0}
        };
        task_values = '{6'd0, 6'd31, 6'($urandom_range(1, 30)), 6'd32};
        idle_mix    = '{'{26, 55}, '{55, 26}, '{0, 0}, '{0, 0}};

        errors = 0; requests_sent = 0; events_seen = 0; switches_seen = 0;
        send_idle = 26; recv_idle = 55; recv_hold = 0;
        for (int i = 0; i < 32; i++) begin
            pool_state[i] = smtq_pkg::ST_FREE; pool_deadline[i] = '0; pool_link[i] = '0;
            pool_owner[i] = '0; pool_word[i] = '0; pool_written[i] = 1'b0;
        end
        list_head = NO_SLOT; head_deadline = smtq_pkg::FAR_DEADLINE; tick_total = '0;
        task_slot = NO_SLOT;

        i_rst_n = 1'b0; i_task_wr = 1'b0; i_task_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, default task slot (none)
        foreach (rows[k]) begin
            send_request(rows[k].act, rows[k].id, rows[k].delay, rows[k].word,
                         rows[k].owner, st);
            if (rows[k].typed && (st.ok !== rows[k].exp_ok || st.slot !== rows[k].exp_slot)) begin
                $error("row %0d status: expected ok %0d slot %0d, model gives ok %0d slot %0d",
                       k, rows[k].exp_ok, rows[k].exp_slot, st.ok, st.slot);
                errors++;
            end
        end

        // random phases
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            write_task_slot(task_values[ph]);
            send_idle = idle_mix[ph][0];
            recv_idle = idle_mix[ph][1];
            if (ph == 1) begin
                // run the pool dry, then free more often
                for (int j = 0; j < 34; j++) begin
                    send_request(smtq_pkg::ACT_ALLOC, 5'd0, 32'd0, 32'd0, 8'd0, st);
                end
            end
            if (ph == 2) recv_hold = 400;
            for (int j = 0; j < 48; j++) random_request(ph == 1 ? 12 : 6);
        end

        wait_idle();
        $display("%0d requests, %0d expiry events and %0d task switches checked",
                 requests_sent, events_seen, switches_seen);
        $display("task slot settings 32, 0, 31, mid and back to none; pool exhaustion and stalls");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
